>>> src/rpn_pkg.sv
// Shared types, constants and codes for the relative path normalizer.
// No dependencies; every other file in src imports this package.
package rpn_pkg;

  localparam int MAX_PATH   = 1024;
  localparam int MAX_SEGS   = 256;

  localparam int POS_W      = $clog2(MAX_PATH);
  localparam int CNT_W      = $clog2(MAX_PATH + 1);
  localparam int SEG_IDX_W  = $clog2(MAX_SEGS);
  localparam int SEG_CNT_W  = $clog2(MAX_SEGS + 1);
  localparam int BANK_W     = POS_W - 1;
  localparam int BANK_DEPTH = MAX_PATH / 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] STAT_CHAR = 2'd0;
  localparam logic [1:0] STAT_OK   = 2'd1;
  localparam logic [1:0] STAT_REJ  = 2'd2;
  localparam logic [1:0] STAT_RD   = 2'd3;

  // segment class while a segment is being typed
  localparam logic [1:0] SEG_EMPTY  = 2'd0;
  localparam logic [1:0] SEG_DOT    = 2'd1;
  localparam logic [1:0] SEG_DOTDOT = 2'd2;
  localparam logic [1:0] SEG_OTHER  = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [7:0]       in_char;
    logic             last;
    logic [POS_W-1:0] rd_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] out_len;
    logic [7:0]       rd_char;
  } out_item_t;

  // one kept segment: text position before its separator, and a ".." mark
  typedef struct packed {
    logic             dotdot;
    logic [POS_W-1:0] pos;
  } seg_ent_t;

  typedef struct packed {
    logic                 push;
    logic [SEG_IDX_W-1:0] wr_addr;
    seg_ent_t             wr_data;
    logic                 pop;
    logic [SEG_IDX_W-1:0] rd_addr;
  } stk_req_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [7:0]       data;
  } ps_port_t;

  // two writes per cycle, always at consecutive addresses
  typedef struct packed {
    ps_port_t a;
    ps_port_t b;
  } ps_wr_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] out_len;
    logic             rd_hit;
  } meta_t;

endpackage

>>> src/relative_path_normalizer.sv
// Relative path normalizer: one character push or one read per item.
// Each result is registered in stage one before it is offered on the result channel.
// Throughput: one item per cycle while the skid is empty; a two-entry result stage absorbs stalls.
// The text store takes a separator and a character in the same cycle via two banks.
// Reset clears the control state only; the text store and stack are not swept.
module relative_path_normalizer import rpn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic             accept;
  seg_ent_t         top;
  ps_wr_t           ps_wr;
  logic             ps_rd_en;
  logic [POS_W-1:0] ps_rd_addr;
  logic [7:0]       rd_data;
  stk_req_t         stk_req;
  meta_t            meta;

  assign accept = in_valid && !in_stall;

  rpn_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .top        (top),
    .ps_wr      (ps_wr),
    .ps_rd_en   (ps_rd_en),
    .ps_rd_addr (ps_rd_addr),
    .stk_req    (stk_req),
    .meta       (meta)
  );

  rpn_path_store u_path_store (
    .clk     (clk),
    .ps_wr   (ps_wr),
    .rd_en   (ps_rd_en),
    .rd_addr (ps_rd_addr),
    .rd_data (rd_data)
  );

  rpn_seg_stack u_seg_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .stk_req (stk_req),
    .top     (top)
  );

  rpn_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .meta      (meta),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .in_stall  (in_stall)
  );

  // the stack top is refetched after a pop; two pops never come back to back
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    stk_req.pop |=> !stk_req.pop)
    else $error("segment pop in consecutive cycles");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_rd_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STAT_RD) |-> (out_item.rd_char == 8'h00))
    else $error("read data on a non-read result");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STAT_OK) |-> (out_item.out_len == '0))
    else $error("length on a result that is not path ok");

endmodule

>>> src/rpn_path_store.sv
// Normalized text store: two byte banks split on address parity.
// Depends on rpn_pkg; a separator and a character land in different banks.
module rpn_path_store import rpn_pkg::*; (
  input  logic             clk,
  input  ps_wr_t           ps_wr,
  input  logic             rd_en,
  input  logic [POS_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] bank0 [BANK_DEPTH];
  logic [7:0] bank1 [BANK_DEPTH];

  logic              b0_en, b1_en;
  logic [BANK_W-1:0] b0_addr, b1_addr;
  logic [7:0]        b0_data, b1_data;
  logic [7:0]        rd0_r, rd1_r;
  logic              sel_r;

  always_comb begin
    b0_en   = 1'b0;
    b0_addr = ps_wr.b.addr[POS_W-1:1];
    b0_data = ps_wr.b.data;
    b1_en   = 1'b0;
    b1_addr = ps_wr.b.addr[POS_W-1:1];
    b1_data = ps_wr.b.data;
    if (ps_wr.a.en && !ps_wr.a.addr[0]) begin
      b0_en   = 1'b1;
      b0_addr = ps_wr.a.addr[POS_W-1:1];
      b0_data = ps_wr.a.data;
    end else if (ps_wr.b.en && !ps_wr.b.addr[0]) begin
      b0_en = 1'b1;
    end
    if (ps_wr.a.en && ps_wr.a.addr[0]) begin
      b1_en   = 1'b1;
      b1_addr = ps_wr.a.addr[POS_W-1:1];
      b1_data = ps_wr.a.data;
    end else if (ps_wr.b.en && ps_wr.b.addr[0]) begin
      b1_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b0_en) begin
      bank0[b0_addr] <= b0_data;
    end
    if (b1_en) begin
      bank1[b1_addr] <= b1_data;
    end
    if (rd_en) begin
      rd0_r <= bank0[rd_addr[POS_W-1:1]];
      rd1_r <= bank1[rd_addr[POS_W-1:1]];
      sel_r <= rd_addr[0];
    end
  end

  assign rd_data = sel_r ? rd1_r : rd0_r;

endmodule

>>> src/rpn_seg_stack.sv
// Kept-segment stack in a synchronous memory with a cached top entry.
// Depends on rpn_pkg; a pop refetches the new top, forwarded the next cycle.
module rpn_seg_stack import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  stk_req_t stk_req,
  output seg_ent_t top
);

  seg_ent_t mem [MAX_SEGS];
  seg_ent_t rd_r;
  seg_ent_t top_r;
  logic     load_r;

  always_ff @(posedge clk) begin
    if (stk_req.push) begin
      mem[stk_req.wr_addr] <= stk_req.wr_data;
    end
    if (stk_req.pop) begin
      rd_r <= mem[stk_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
    end else begin
      load_r <= stk_req.pop;
    end
  end

  // a push always wins over a pending refetch
  always_ff @(posedge clk) begin
    if (stk_req.push) begin
      top_r <= stk_req.wr_data;
    end else if (load_r) begin
      top_r <= rd_r;
    end
  end

  assign top = load_r ? rd_r : top_r;

endmodule

>>> src/rpn_core.sv
// Per-character path state: segment classing, separators, pops and pushes.
// Depends on rpn_pkg; drives the text store, the segment stack and stage one.
module rpn_core import rpn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_item_t         in_item,
  input  seg_ent_t         top,
  output ps_wr_t           ps_wr,
  output logic             ps_rd_en,
  output logic [POS_W-1:0] ps_rd_addr,
  output stk_req_t         stk_req,
  output meta_t            meta
);

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

  logic [SEG_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]     wp_r, wp_nxt;
  logic [POS_W-1:0]     start_r, start_nxt;
  logic [1:0]           cls_r, cls_nxt;
  logic [CNT_W-1:0]     cc_r, cc_nxt;
  logic [15:0]          head_r, head_nxt;
  logic                 failed_r, failed_nxt;
  logic [POS_W-1:0]     done_len_r, done_len_nxt;

  logic [7:0] ch;
  logic       is_slash;
  logic       do_end;
  logic [1:0] end_cls;

  always_comb begin
    ch           = (in_item.in_char == CH_BSLASH) ? CH_SLASH : in_item.in_char;
    is_slash     = (ch == CH_SLASH);
    do_end       = 1'b0;
    end_cls      = SEG_EMPTY;
    cnt_nxt      = cnt_r;
    wp_nxt       = wp_r;
    start_nxt    = start_r;
    cls_nxt      = cls_r;
    cc_nxt       = cc_r;
    head_nxt     = head_r;
    failed_nxt   = failed_r;
    done_len_nxt = done_len_r;
    ps_wr        = '0;
    stk_req      = '0;
    meta         = '0;
    ps_rd_en     = accept && (in_item.cmd == CMD_READ);
    ps_rd_addr   = in_item.rd_index;

    if (in_item.cmd == CMD_READ) begin
      meta.status = STAT_RD;
      meta.rd_hit = (in_item.rd_index < done_len_r);
    end else if (accept) begin
      // screen the head of the path and its length
      if (cc_r == '0) begin
        done_len_nxt = '0;
        head_nxt     = {8'h00, ch};
        if (is_slash) begin
          failed_nxt = 1'b1;
        end
      end else if (cc_r == CNT_W'(1)) begin
        head_nxt[15:8] = ch;
      end else if (cc_r == CNT_W'(2)) begin
        if (is_letter(head_r[7:0]) && head_r[15:8] == CH_COLON && is_slash) begin
          failed_nxt = 1'b1;
        end
      end
      if (cc_r >= CNT_W'(MAX_PATH - 1)) begin
        failed_nxt = 1'b1;
      end
      if (cc_r < CNT_W'(MAX_PATH)) begin
        cc_nxt = cc_r + CNT_W'(1);
      end

      if (!failed_nxt) begin
        if (is_slash) begin
          do_end  = 1'b1;
          end_cls = cls_r;
        end else begin
          if (cls_r == SEG_EMPTY) begin
            start_nxt = wp_r;
            if (cnt_r != '0) begin
              ps_wr.a.en   = 1'b1;
              ps_wr.a.addr = wp_r;
              ps_wr.a.data = CH_SLASH;
              wp_nxt       = wp_r + POS_W'(1);
            end
          end
          ps_wr.b.en   = 1'b1;
          ps_wr.b.addr = wp_nxt;
          ps_wr.b.data = ch;
          wp_nxt       = wp_nxt + POS_W'(1);
          if (ch == CH_DOT && (cls_r == SEG_EMPTY || cls_r == SEG_DOT)) begin
            cls_nxt = cls_r + 2'd1;
          end else begin
            cls_nxt = SEG_OTHER;
          end
          if (in_item.last) begin
            do_end  = 1'b1;
            end_cls = cls_nxt;
          end
        end
      end

      // close the segment: drop, pop, push or overflow
      if (do_end) begin
        cls_nxt = SEG_EMPTY;
        if (end_cls == SEG_DOT) begin
          wp_nxt = start_nxt;
        end else if (end_cls != SEG_EMPTY) begin
          if (end_cls == SEG_DOTDOT && cnt_r != '0 && !top.dotdot) begin
            cnt_nxt         = cnt_r - SEG_CNT_W'(1);
            wp_nxt          = top.pos;
            stk_req.pop     = 1'b1;
            stk_req.rd_addr = SEG_IDX_W'(cnt_r - SEG_CNT_W'(2));
          end else if (cnt_r >= SEG_CNT_W'(MAX_SEGS)) begin
            failed_nxt = 1'b1;
          end else begin
            stk_req.push           = 1'b1;
            stk_req.wr_addr        = cnt_r[SEG_IDX_W-1:0];
            stk_req.wr_data.dotdot = (end_cls == SEG_DOTDOT);
            stk_req.wr_data.pos    = start_nxt;
            cnt_nxt                = cnt_r + SEG_CNT_W'(1);
          end
        end
      end

      if (in_item.last) begin
        if (!failed_nxt && cnt_nxt != '0) begin
          meta.status  = STAT_OK;
          meta.out_len = wp_nxt;
          done_len_nxt = wp_nxt;
        end else begin
          meta.status  = STAT_REJ;
          done_len_nxt = '0;
        end
        cnt_nxt    = '0;
        wp_nxt     = '0;
        start_nxt  = '0;
        cls_nxt    = SEG_EMPTY;
        cc_nxt     = '0;
        head_nxt   = '0;
        failed_nxt = 1'b0;
      end else begin
        meta.status = STAT_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      wp_r       <= '0;
      start_r    <= '0;
      cls_r      <= SEG_EMPTY;
      cc_r       <= '0;
      head_r     <= '0;
      failed_r   <= 1'b0;
      done_len_r <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      wp_r       <= wp_nxt;
      start_r    <= start_nxt;
      cls_r      <= cls_nxt;
      cc_r       <= cc_nxt;
      head_r     <= head_nxt;
      failed_r   <= failed_nxt;
      done_len_r <= done_len_nxt;
    end
  end

endmodule

>>> src/rpn_out.sv
// Result stage and skid buffer between the core and the result channel.
// Depends on rpn_pkg; merges read data from the text store into the item.
module rpn_out import rpn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  meta_t     meta,
  input  logic [7:0] rd_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item,
  output logic      in_stall
);

  meta_t     s1_meta_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_r;
  out_item_t s1_item;

  always_comb begin
    s1_item.status  = s1_meta_r.status;
    s1_item.out_len = s1_meta_r.out_len;
    s1_item.rd_char = s1_meta_r.rd_hit ? rd_data : 8'h00;
  end

  // with the skid full no item enters, so stage one and the read data hold
  assign s1_valid_nxt   = skid_valid_r ? s1_valid_r : accept;
  assign skid_valid_nxt = skid_valid_r ? out_stall : (s1_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (!skid_valid_r) begin
      skid_r <= s1_item;
    end
  end

  assign out_valid = skid_valid_r || s1_valid_r;
  assign out_item  = skid_valid_r ? skid_r : s1_item;
  assign in_stall  = skid_valid_r;

endmodule

>>> verif/path_check.sv
// Path checker: watches both channels of relative_path_normalizer, predicts each
// result and compares it field by field. Depends on rpn_pkg for item types.
`timescale 1ns / 100ps

module path_check import rpn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);

  logic [7:0] text_mem [MAX_PATH];
  seg_ent_t   seg_mem [MAX_SEGS];
  int         n_segs, wr_pos, seg_start, char_cnt, done_len;
  logic [1:0] seg_kind;
  logic [7:0] first_ch, second_ch;
  bit         rejected;
  out_item_t  awaited[$];

  function automatic void clear_path_state();
    n_segs    = 0;
    wr_pos    = 0;
    seg_start = 0;
    seg_kind  = SEG_EMPTY;
    char_cnt  = 0;
    first_ch  = '0;
    second_ch = '0;
    rejected  = 1'b0;
  endfunction

  function automatic void store_byte(logic [7:0] c);
    if (wr_pos < MAX_PATH) begin
      text_mem[wr_pos] = c;
      wr_pos++;
    end
  endfunction

  // close the segment just typed: drop it, pop its parent, or keep it
  function automatic void close_segment();
    logic [1:0] kind;
    seg_ent_t   ent;
    kind     = seg_kind;
    seg_kind = SEG_EMPTY;
    if (kind == SEG_EMPTY) return;
    if (kind == SEG_DOT) begin
      wr_pos = seg_start;
      return;
    end
    if (kind == SEG_DOTDOT && n_segs > 0) begin
      ent = seg_mem[n_segs - 1];
      if (!ent.dotdot) begin
        n_segs--;
        wr_pos = ent.pos;
        return;
      end
    end
    if (n_segs >= MAX_SEGS) begin
      rejected = 1'b1;
      return;
    end
    ent.dotdot = (kind == SEG_DOTDOT);
    ent.pos    = POS_W'(seg_start);
    seg_mem[n_segs] = ent;
    n_segs++;
  endfunction

  function automatic out_item_t normalize_step(in_item_t it);
    out_item_t  r;
    logic [7:0] ch;
    r = '0;
    if (it.cmd == CMD_READ) begin
      r.status = STAT_RD;
      if (it.rd_index < done_len) r.rd_char = text_mem[it.rd_index];
      return r;
    end
    ch = (it.in_char == CH_BSLASH) ? CH_SLASH : it.in_char;
    // first character of a new path hides the previous result
    if (char_cnt == 0) begin
      done_len = 0;
      first_ch = ch;
      if (ch == CH_SLASH) rejected = 1'b1;
    end else if (char_cnt == 1) begin
      second_ch = ch;
    end else if (char_cnt == 2) begin
      if (((first_ch >= 8'h41 && first_ch <= 8'h5A) || (first_ch >= 8'h61 && first_ch <= 8'h7A))
          && second_ch == CH_COLON && ch == CH_SLASH)
        rejected = 1'b1;
    end
    if (char_cnt + 1 >= MAX_PATH) rejected = 1'b1;
    if (char_cnt < MAX_PATH) char_cnt++;
    if (!rejected) begin
      if (ch == CH_SLASH) begin
        close_segment();
      end else begin
        if (seg_kind == SEG_EMPTY) begin
          seg_start = wr_pos;
          if (n_segs > 0) store_byte(CH_SLASH);
        end
        store_byte(ch);
        if (ch == CH_DOT && seg_kind == SEG_EMPTY) seg_kind = SEG_DOT;
        else if (ch == CH_DOT && seg_kind == SEG_DOT) seg_kind = SEG_DOTDOT;
        else seg_kind = SEG_OTHER;
      end
    end
    if (it.last) begin
      if (!rejected) close_segment();
      if (!rejected && n_segs > 0) begin
        done_len  = wr_pos % MAX_PATH;
        r.status  = STAT_OK;
        r.out_len = POS_W'(done_len);
      end else begin
        done_len = 0;
        r.status = STAT_REJ;
      end
      clear_path_state();
    end
    return r;
  endfunction

  function automatic void report(string what, out_item_t want, out_item_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t path_check %s: want %0d/%0d/%h got %0d/%0d/%h (status/len/char)",
               $time, what, want.status, want.out_len, want.rd_char,
               got.status, got.out_len, got.rd_char);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_path_state();
      done_len = 0;
      awaited.delete();
    end else begin
      if (in_valid && !in_stall) awaited.push_back(normalize_step(in_item));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report("result with none pending", '0, out_item);
        end else begin
          want = awaited.pop_front();
          if (want.status !== out_item.status || want.out_len !== out_item.out_len ||
              want.rd_char !== out_item.rd_char)
            report("mismatch", want, out_item);
        end
      end
    end
    outstanding <= awaited.size();
  end

endmodule

>>> verif/tb.sv
// Top of the relative_path_normalizer testbench: clock, reset, path and read
// stimulus, stall bursts and the verdict. Depends on rpn_pkg and path_check.
`timescale 1ns / 100ps

module tb;
  import rpn_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int TAIL_ITEMS   = 60;
  localparam int STALL_LIMIT  = 1000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, outstanding;

  int         in_gap_pct = 0;
  int         out_hold_pct = 0;
  bit         quiet_tail = 1'b0;
  int         items_sent = 0;
  logic [7:0] path_buf[$];

  string directed_paths[$] = '{
    "a", "a/b/c", "./a//b/", "a\\b\\..\\c", "../../x", "a/../../b", "a/b/../../..",
    ".", "a/..", "//", "/a", "\\a", "A:/w", "z:\\w", "Z:/w", "a:/w", "@:/w", "[:/w",
    "`:/w", "{:/w", "C:w", "...", ".a/a./..b", "x/./y/.", "../a/../.."
  };

  always #4 clk = ~clk;

  relative_path_normalizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  path_check u_path_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // offer one item, maybe after a gap, and hold it until taken
  task automatic send(in_item_t it);
    if (!quiet_tail && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c, logic l);
    in_item_t it;
    it.cmd      = CMD_PUSH;
    it.in_char  = c;
    it.last     = l;
    it.rd_index = POS_W'($urandom_range(0, MAX_PATH - 2));
    send(it);
  endtask

  task automatic send_reads(int n, int lo, int hi);
    in_item_t it;
    if (hi > MAX_PATH - 2) hi = MAX_PATH - 2;
    repeat (n) begin
      it.cmd      = CMD_READ;
      it.in_char  = 8'($urandom_range(0, 255));
      it.last     = 1'($urandom_range(0, 1));
      it.rd_index = POS_W'($urandom_range(lo, hi));
      send(it);
    end
  endtask

  // push the buffered path, with a stray read now and then, then read it back
  task automatic send_path(int n_reads);
    int len;
    len = path_buf.size();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 2) send_reads(1, 0, MAX_PATH - 2);
      send_char(path_buf[i], i == len - 1);
    end
    path_buf.delete();
    send_reads(n_reads, 0, len + 1);
  endtask

  function automatic logic [7:0] pick_sep();
    return ($urandom_range(0, 3) == 0) ? CH_BSLASH : CH_SLASH;
  endfunction

  task automatic add_segment();
    case ($urandom_range(0, 9))
      0: ;
      1: path_buf.push_back(CH_DOT);
      2, 3: begin
        path_buf.push_back(CH_DOT);
        path_buf.push_back(CH_DOT);
      end
      default: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 5))
            0: path_buf.push_back(CH_DOT);
            1: path_buf.push_back(8'($urandom_range(1, 255)));
            2: path_buf.push_back(CH_COLON);
            default: path_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
          endcase
        end
      end
    endcase
  endtask

  task automatic add_random_path();
    int n_seg;
    case ($urandom_range(0, 19))
      0: path_buf.push_back(pick_sep());
      1: begin
        path_buf.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)));
        path_buf.push_back(CH_COLON);
        path_buf.push_back(pick_sep());
      end
      default: ;
    endcase
    n_seg = $urandom_range(1, 8);
    for (int s = 0; s < n_seg; s++) begin
      if (s != 0) path_buf.push_back(pick_sep());
      add_segment();
    end
    if ($urandom_range(0, 4) == 0) path_buf.push_back(pick_sep());
    if (path_buf.size() == 0) path_buf.push_back(CH_DOT);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 99) < out_hold_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int start;
    string s;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    in_gap_pct = 10;
    out_hold_pct <= 10;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_paths[k]) begin
      s = directed_paths[k];
      for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
      send_path(3);
    end

    // zero and top-bit bytes are plain segment characters
    path_buf.push_back(8'h00);
    path_buf.push_back(CH_SLASH);
    path_buf.push_back(8'hFF);
    path_buf.push_back(8'h80);
    send_path(4);

    // reads between characters of a new path see nothing
    path_buf.push_back(8'h61);
    path_buf.push_back(8'h62);
    send_path(2);
    send_char(8'h63, 1'b0);
    send_reads(2, 0, 3);
    send_char(8'h64, 1'b1);
    send_reads(2, 0, 3);

    // longest accepted path: three-letter segments that fill the stack exactly
    for (int i = 0; i < MAX_PATH - 1; i++)
      path_buf.push_back((i % 4 == 3) ? pick_sep() : 8'h61 + 8'(i % 26));
    send_path(4);
    send_reads(1, MAX_PATH - 2, MAX_PATH - 2);

    // one segment more than the stack holds
    for (int i = 0; i <= MAX_SEGS; i++) begin
      if (i != 0) path_buf.push_back(pick_sep());
      path_buf.push_back(8'h7A);
    end
    send_path(2);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet_tail <= (items_sent - start > RANDOM_ITEMS - TAIL_ITEMS);
      case ($urandom_range(0, 3))
        0: begin
          in_gap_pct = 0;
          out_hold_pct <= 0;
        end
        1: begin
          in_gap_pct = 3;
          out_hold_pct <= 3;
        end
        default: begin
          in_gap_pct = $urandom_range(5, 30);
          out_hold_pct <= $urandom_range(5, 30);
        end
      endcase
      add_random_path();
      send_path($urandom_range(0, 4));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
